>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the packet queue design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Strict priority queue package
// Widths, defaults, commands and status shared by the queue modules.
// ----------------------------------------------------------------------------
`default_nettype none
package spq_pkg;
    localparam int DEF_LEVELS   = 8;
    localparam int DEF_DEPTH    = 16;
    localparam int DEF_MAX_SEND = 64;
    localparam int TAG_W        = 16;
    localparam int PRIO_W       = 3;
    localparam int LIMIT_W      = 7;
    localparam int QLIM_W       = 5;
    localparam logic [QLIM_W-1:0] QLIM_RESET = 5'd16;
    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_SEND    = 1'b1;

    typedef struct packed {
        logic load;      // capture the input word
        logic scan;      // step level pointer down by one (send) or start thinning
        logic thin_step; // read entry to move; commit thinned count at end
        logic thin_done; // write moved entry and advance index
        logic append;    // write received tag
        logic read;      // issue read of head entry
        logic pop;       // emit read data and advance head
    } spq_cmd_t;

    typedef struct packed {
        logic is_send;
        logic need_thin;
        logic thin_more;
        logic lvl_nonempty;
        logic lvl_zero;
        logic quota_left;
    } spq_stat_t;
endpackage
`default_nettype wire

>>> rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// Strict priority queue datapath
// Tag memory, per-level counters and heads, thinning and drain registers.
// ----------------------------------------------------------------------------
`default_nettype none
module spq_datapath #(
    parameter int LEVELS   = spq_pkg::DEF_LEVELS,
    parameter int DEPTH    = spq_pkg::DEF_DEPTH,
    parameter int MAX_SEND = spq_pkg::DEF_MAX_SEND
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [spq_pkg::QLIM_W-1:0]  cfg_data,
    input  wire logic                        operation,
    input  wire logic [spq_pkg::TAG_W-1:0]   packet_tag,
    input  wire logic [spq_pkg::PRIO_W-1:0]  priority_req,
    input  wire logic [spq_pkg::LIMIT_W-1:0] send_limit,
    input  wire spq_pkg::spq_cmd_t           cmd,
    output spq_pkg::spq_stat_t               stat,
    output logic [spq_pkg::TAG_W-1:0]        out_tag,
    output logic [spq_pkg::PRIO_W-1:0]       out_prio,
    output logic                             out_last
);
    import spq_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(MAX_SEND + 1);
    localparam int AW = LW + DW;

    logic [TAG_W-1:0] mem [LEVELS*DEPTH];
    logic [CW-1:0] count_reg [LEVELS];
    logic [DW-1:0] head_reg [LEVELS];
    logic [QLIM_W-1:0] qlim_reg;
    logic          op_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic [SW-1:0] quota_reg, quota_next;
    logic [CW-1:0] idx_reg, idx_next, keep_reg, keep_next;
    logic [TAG_W-1:0] rd_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [CW-1:0] cnt, thresh, keep_now;
    logic [DW-1:0] hd;
    logic          lower_busy;

    assign cnt = count_reg[lvl_reg];
    assign hd  = head_reg[lvl_reg];

    always_comb
    begin
        logic [CW:0] t;
        t = (32'(qlim_reg) < DEPTH) ? (CW+1)'(qlim_reg) : (CW+1)'(DEPTH);
        thresh = t[CW-1:0];
    end

    assign keep_now = CW'(({1'b0, cnt} + 1'b1) >> 1);

    always_comb
    begin
        lower_busy = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            if (i < 32'(lvl_reg) && count_reg[i] != '0) begin
                lower_busy = 1'b1;
            end
        end
    end

    function automatic logic [AW-1:0] slot(input logic [LW-1:0] l, input logic [DW-1:0] h,
                                           input logic [CW-1:0] p);
        logic [DW:0] s;
        logic [DW-1:0] w;
        s = {1'b0, h} + (DW+1)'(p);
        w = (32'(s) >= DEPTH) ? DW'(32'(s) - DEPTH) : s[DW-1:0];
        slot = AW'(32'(l) * DEPTH + 32'(w));
    endfunction

    always_comb
    begin
        logic [CW:0] twice;
        twice = {idx_reg, 1'b0};
        rd_addr = slot(lvl_reg, hd, {CW{1'b0}});
        wr_addr = slot(lvl_reg, hd, cnt);
        wr_en = 1'b0;
        if (cmd.scan || cmd.thin_step) begin
            rd_addr = slot(lvl_reg, hd, twice[CW-1:0]);
        end
        if (cmd.read) begin
            rd_addr = slot(lvl_reg, hd, {CW{1'b0}});
        end
        if (cmd.thin_done && idx_reg != {CW{1'b0}}) begin
            wr_en = 1'b1;
            wr_addr = slot(lvl_reg, hd, idx_reg);
        end
        if (cmd.append) begin
            wr_en = 1'b1;
            wr_addr = slot(lvl_reg, hd, cnt);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= cmd.append ? tag_reg : rd_reg;
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        lvl_next = lvl_reg;
        quota_next = quota_reg;
        idx_next = idx_reg;
        keep_next = keep_reg;
        if (cmd.load) begin
            if (operation == OP_SEND) begin
                lvl_next = LW'(LEVELS - 1);
            end else if (32'(priority_req) >= LEVELS) begin
                lvl_next = LW'(LEVELS - 1);
            end else begin
                lvl_next = LW'(priority_req);
            end
            quota_next = (32'(send_limit) > MAX_SEND) ? SW'(MAX_SEND) : SW'(send_limit);
        end
        if (cmd.scan) begin
            if (op_reg == OP_SEND) begin
                lvl_next = lvl_reg - 1'b1;
            end
            idx_next = CW'(1);
            keep_next = keep_now;
        end
        if (cmd.thin_done) begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.pop) begin
            quota_next = quota_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            qlim_reg <= QLIM_RESET;
            for (int i = 0; i < LEVELS; i++) begin
                count_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                qlim_reg <= cfg_data;
            end
            if (cmd.thin_step && !(idx_reg < keep_reg)) begin
                count_reg[lvl_reg] <= keep_reg;
            end
            if (cmd.append) begin
                count_reg[lvl_reg] <= cnt + 1'b1;
            end
            if (cmd.pop) begin
                count_reg[lvl_reg] <= cnt - 1'b1;
                head_reg[lvl_reg] <= (32'(hd) == DEPTH - 1) ? '0 : hd + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
        quota_reg <= quota_next;
        idx_reg <= idx_next;
        keep_reg <= keep_next;
        if (cmd.load) begin
            op_reg <= operation;
            tag_reg <= packet_tag;
        end
        if (cmd.pop) begin
            out_tag <= rd_reg;
            out_prio <= PRIO_W'(lvl_reg);
            out_last <= (quota_reg == SW'(1)) ||
                        (cnt == CW'(1) && !lower_busy);
        end
    end

    always_comb
    begin
        stat.is_send = (op_reg == OP_SEND);
        stat.need_thin = (cnt >= thresh) || (32'(cnt) >= DEPTH);
        stat.thin_more = idx_reg < keep_reg;
        stat.lvl_nonempty = cnt != '0;
        stat.lvl_zero = lvl_reg == '0;
        stat.quota_left = quota_reg != '0;
    end
endmodule
`default_nettype wire

>>> rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Strict priority queue controller
// Sequences receive thinning and append, and the send drain.
// ----------------------------------------------------------------------------
`default_nettype none
module spq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t       cmd
);
    import spq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_THRD  = 3'd2;
    localparam logic [2:0] S_THWR  = 3'd3;
    localparam logic [2:0] S_APP   = 3'd4;
    localparam logic [2:0] S_FIND  = 3'd5;
    localparam logic [2:0] S_RD    = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       out_free;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        ov_next = ov_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.is_send) begin
                    state_next = stat.quota_left ? S_FIND : S_IDLE;
                end else if (stat.need_thin) begin
                    cmd.scan = 1'b1;
                    state_next = S_THRD;
                end else begin
                    state_next = S_APP;
                end
            end
            S_THRD:
            begin
                cmd.thin_step = 1'b1;
                state_next = stat.thin_more ? S_THWR : S_APP;
            end
            S_THWR:
            begin
                cmd.thin_done = 1'b1;
                state_next = S_THRD;
            end
            S_APP:
            begin
                cmd.append = 1'b1;
                state_next = S_IDLE;
            end
            S_FIND:
            begin
                if (!stat.quota_left) begin
                    state_next = S_IDLE;
                end else if (stat.lvl_nonempty) begin
                    cmd.read = 1'b1;
                    state_next = S_RD;
                end else if (stat.lvl_zero) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            S_RD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free) begin
                    cmd.pop = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_FIND;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule
`default_nettype wire

>>> rtl/strict_priority_packet_queues.sv
// ----------------------------------------------------------------------------
// Strict priority packet queues
// Per-level tag FIFOs with thinning on receive and strict priority drain.
// ----------------------------------------------------------------------------
// Channel  Handshake        Payload
// in       valid / stall    operation, packet_tag, priority_req, send_limit
// out      valid / stall    sent_tag, sent_priority, last
// cfg      cfg_we           cfg_data (queue_limit)
// A receive loads, decodes and appends; thinning first moves each kept entry after the first.
// A send loads and decodes, then finds, reads and emits each word, stepping past empty levels.
// A zero limit stops at decode; tag memory reads are registered; one item is handled at a time.
// Reset empties every level and sets queue_limit to 16; no clearing pass.
// A stalled output holds the drain until the word is taken.
`default_nettype none
module strict_priority_packet_queues #(
    parameter int LEVELS   = spq_pkg::DEF_LEVELS,
    parameter int DEPTH    = spq_pkg::DEF_DEPTH,
    parameter int MAX_SEND = spq_pkg::DEF_MAX_SEND
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [spq_pkg::QLIM_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        operation,
    input  wire logic [spq_pkg::TAG_W-1:0]   packet_tag,
    input  wire logic [spq_pkg::PRIO_W-1:0]  priority_req,
    input  wire logic [spq_pkg::LIMIT_W-1:0] send_limit,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [spq_pkg::TAG_W-1:0]        sent_tag,
    output logic [spq_pkg::PRIO_W-1:0]       sent_priority,
    output logic                             last
);
    import spq_pkg::*;
`include "assert_macros.svh"

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .LEVELS   (LEVELS),
        .DEPTH    (DEPTH),
        .MAX_SEND (MAX_SEND)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .packet_tag   (packet_tag),
        .priority_req (priority_req),
        .send_limit   (send_limit),
        .cmd          (cmd),
        .stat         (stat),
        .out_tag      (sent_tag),
        .out_prio     (sent_priority),
        .out_last     (last)
    );

    `ASSERT_ALWAYS(a_pop_room, clk, rst_n, !(cmd.pop && out_valid && out_stall), "pop into full output")
    `ASSERT_ALWAYS(a_no_accept_busy, clk, rst_n, !(cmd.load && in_stall), "load while busy")
    `ASSERT_NEXT(a_pop_valid, clk, rst_n, cmd.pop, out_valid, "pop without output word")
    `ASSERT_ALWAYS(a_one_write, clk, rst_n, !(cmd.append && cmd.thin_done), "two writes at once")
endmodule
`default_nettype wire
